>>> rtl/core/ultrasonic_echo_ranger_top_defines.svh
// ----------------------------------------------------------------------------
// Echo ranger assertion macros
// Shared property wrappers for the ranger's checker.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_TOP_DEFINES_SVH
`define ULTRASONIC_ECHO_RANGER_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define UER_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, held off during reset
`define UER_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/uer_pkg.sv
// ----------------------------------------------------------------------------
// Echo ranger package
// Phase and status codes, register indexes, divide constants and shared types.
// ----------------------------------------------------------------------------
package uer_pkg;

   // measurement phases
   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_CLEAR     = 3'd1;
   localparam logic [2:0] PH_TRIG_LOW  = 3'd2;
   localparam logic [2:0] PH_TRIG_HIGH = 3'd3;
   localparam logic [2:0] PH_RISE      = 3'd4;
   localparam logic [2:0] PH_COUNT     = 3'd5;

   // result status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_STUCK     = 3'd1;
   localparam logic [2:0] ST_NO_RISE   = 3'd2;
   localparam logic [2:0] ST_TOO_LONG  = 3'd3;
   localparam logic [2:0] ST_RANGE     = 3'd4;

   // register indexes
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_TRIGGER_WIDTH = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLEAR_TIMEOUT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_RISE_TIMEOUT  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ECHO      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DIST      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DIST      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_FAIL_LIMIT    = 3'd6;

   localparam logic [15:0] TRIG_LOW_TICKS = 16'd2;
   localparam logic [15:0] TICKS_PER_CM   = 16'd58;

   // (16*count + 29) / 58 by reciprocal: exact for numerators below 2^19
   localparam logic [18:0] ROUND_HALF   = 19'd29;
   localparam logic [19:0] DIV58_MUL    = 20'd578525;
   localparam int          DIV58_SHIFT  = 25;

   typedef struct packed {
      logic [7:0]  trigger_width;
      logic [15:0] clear_timeout;
      logic [15:0] rise_timeout;
      logic [15:0] max_echo;
      logic [8:0]  min_distance_cm;
      logic [8:0]  max_distance_cm;
      logic [7:0]  fail_limit;
   } cfg_type;

   typedef struct packed {
      logic        trigger;
      logic        busy_res;
      logic        done_res;
      logic [2:0]  status;
      logic [12:0] reported_distance;
      logic [12:0] last_good_distance;
      logic [7:0]  failures;
   } rsp_type;

endpackage

>>> rtl/core/ultrasonic_echo_ranger_top.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger
// Time-of-flight ranging on a one-microsecond tick stream.
// ----------------------------------------------------------------------------
//
//  Port group  Dir  Transfer carries
//  ----------  ---  ---------------------------------------------------------
//  req_*       in   one tick: start request and sampled echo level
//  rsp_*       out  one result per tick: trigger, flags, status, distances
//  csr_*       in   register write, index 0..6, taken on any clock edge with write enable high
//
//  Throughput: one tick per clock while the rsp side is not stalled. A tick
//  is held in the input register, then the phase machine and the divide-by-58
//  multiply produce its result into the output register once that is free.
//  The state loop (phase, tick counter, failure count) closes through the fsm's own registers.
//  Reset (synchronous) returns the machine to idle, clears counts/distances
//  and loads register defaults. A stalled rsp side holds the output register;
//  one more tick may sit in the input register before req_tready drops.
//
module ultrasonic_echo_ranger_top (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata: [0] start_req, [1] echo, [7:2] zero
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,
   // rsp_tdata: [0] trigger, [1] busy_res, [2] done_res, [5:3] status,
   //            [18:6] reported_distance, [31:19] last_good_distance,
   //            [39:32] failures
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [39:0]                    rsp_tdata,
   input  logic                           csr_wr_en,
   input  logic [uer_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [uer_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import uer_pkg::*;

   cfg_type     cfg_ff;
   logic        in_valid_ff, in_valid_in;
   logic        in_start_ff;
   logic        in_echo_ff;
   logic        out_valid_ff, out_valid_in;
   logic [39:0] out_data_ff;
   logic        out_free;
   logic        step;
   rsp_type     rsp;

   // output register takes a new result when empty or being drained
   assign out_free     = !out_valid_ff || rsp_tready;
   assign step         = in_valid_ff && out_free;
   assign req_tready   = !in_valid_ff || out_free;
   assign in_valid_in  = (req_tvalid && req_tready) || (in_valid_ff && !out_free);
   assign out_valid_in = step || (out_valid_ff && !rsp_tready);

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_width   <= 8'd10;
         cfg_ff.clear_timeout   <= 16'd3000;
         cfg_ff.rise_timeout    <= 16'd6000;
         cfg_ff.max_echo        <= 16'd25000;
         cfg_ff.min_distance_cm <= 9'd2;
         cfg_ff.max_distance_cm <= 9'd400;
         cfg_ff.fail_limit      <= 8'd4;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_TRIGGER_WIDTH: cfg_ff.trigger_width   <= csr_wdata[7:0];
            CSR_CLEAR_TIMEOUT: cfg_ff.clear_timeout   <= csr_wdata;
            CSR_RISE_TIMEOUT:  cfg_ff.rise_timeout    <= csr_wdata;
            CSR_MAX_ECHO:      cfg_ff.max_echo        <= csr_wdata;
            CSR_MIN_DIST:      cfg_ff.min_distance_cm <= csr_wdata[8:0];
            CSR_MAX_DIST:      cfg_ff.max_distance_cm <= csr_wdata[8:0];
            CSR_FAIL_LIMIT:    cfg_ff.fail_limit      <= csr_wdata[7:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_start_ff <= req_tdata[0];
         in_echo_ff  <= req_tdata[1];
      end
   end

   uer_fsm u_fsm (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .start_req (in_start_ff),
      .echo      (in_echo_ff),
      .cfg       (cfg_ff),
      .rsp       (rsp)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_data_ff <= {rsp.failures, rsp.last_good_distance, rsp.reported_distance,
                         rsp.status, rsp.done_res, rsp.busy_res, rsp.trigger};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

>>> rtl/core/uer_fsm.sv
// ----------------------------------------------------------------------------
// Echo ranger sequencer
// Per-tick phase machine, tick counter, failure count and distance conversion.
// ----------------------------------------------------------------------------
module uer_fsm (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  logic             start_req,
   input  logic             echo,
   input  uer_pkg::cfg_type cfg,
   output uer_pkg::rsp_type rsp
);
   import uer_pkg::*;

   logic [2:0]  phase_ff, phase_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [7:0]  fails_ff, fails_in;
   logic [12:0] good_ff, good_in;
   logic [12:0] caller_ff, caller_in;

   logic [2:0]  ph;
   logic [15:0] cnt;
   logic [16:0] cnt_inc;
   logic [7:0]  fails_sat;
   logic [15:0] min_ticks, max_ticks;
   logic        in_range;
   logic [18:0] num;
   logic [38:0] prod;
   logic [12:0] dist_cm16;
   logic        trig, done, fail;
   logic [2:0]  status;

   // distance path works from the stored count only
   assign min_ticks = 16'(cfg.min_distance_cm) * TICKS_PER_CM;
   assign max_ticks = 16'(cfg.max_distance_cm) * TICKS_PER_CM;
   assign in_range  = (cnt_ff >= min_ticks) && (cnt_ff <= max_ticks);
   assign num       = {cnt_ff[14:0], 4'b0000} + ROUND_HALF;
   assign prod      = 39'(num) * 39'(DIV58_MUL);
   assign dist_cm16 = prod[DIV58_SHIFT +: 13];

   assign fails_sat = (fails_ff != 8'hFF) ? fails_ff + 8'd1 : fails_ff;

   always_comb begin
      ph       = phase_ff;
      cnt      = cnt_ff;
      if (phase_ff == PH_IDLE && start_req) begin
         ph  = PH_CLEAR;
         cnt = 16'd0;
      end
      cnt_inc  = {1'b0, cnt} + 17'd1;
      phase_in = ph;
      cnt_in   = cnt;
      trig     = 1'b0;
      done     = 1'b0;
      fail     = 1'b0;
      status   = ST_OK;
      case (ph)
         PH_CLEAR: begin
            if (!echo) begin
               phase_in = PH_TRIG_LOW;
               cnt_in   = 16'd0;
            end else begin
               cnt_in = cnt_inc[15:0];
               if (cnt_inc >= {1'b0, cfg.clear_timeout}) begin
                  fail   = 1'b1;
                  status = ST_STUCK;
               end
            end
         end
         PH_TRIG_LOW: begin
            cnt_in = cnt_inc[15:0];
            if (cnt_inc >= {1'b0, TRIG_LOW_TICKS}) begin
               phase_in = PH_TRIG_HIGH;
               cnt_in   = 16'd0;
            end
         end
         PH_TRIG_HIGH: begin
            trig   = 1'b1;
            cnt_in = cnt_inc[15:0];
            if (cnt_inc >= 17'(cfg.trigger_width)) begin
               phase_in = PH_RISE;
               cnt_in   = 16'd0;
            end
         end
         PH_RISE: begin
            if (echo) begin
               if (cfg.max_echo == 16'd0) begin
                  fail   = 1'b1;
                  status = ST_TOO_LONG;
               end else begin
                  phase_in = PH_COUNT;
                  cnt_in   = 16'd1;
               end
            end else begin
               cnt_in = cnt_inc[15:0];
               if (cnt_inc >= {1'b0, cfg.rise_timeout}) begin
                  fail   = 1'b1;
                  status = ST_NO_RISE;
               end
            end
         end
         PH_COUNT: begin
            if (echo) begin
               if (cnt >= cfg.max_echo) begin
                  fail   = 1'b1;
                  status = ST_TOO_LONG;
               end else begin
                  cnt_in = cnt_inc[15:0];
               end
            end else if (in_range) begin
               done     = 1'b1;
               phase_in = PH_IDLE;
               cnt_in   = 16'd0;
            end else begin
               fail   = 1'b1;
               status = ST_RANGE;
            end
         end
         default: begin
            phase_in = PH_IDLE;
            cnt_in   = 16'd0;
         end
      endcase

      fails_in  = fails_ff;
      good_in   = good_ff;
      caller_in = caller_ff;
      if (fail) begin
         done     = 1'b1;
         phase_in = PH_IDLE;
         cnt_in   = 16'd0;
         fails_in = fails_sat;
         if (fails_sat > cfg.fail_limit) begin
            caller_in = 13'd0;
         end
      end else if (done) begin
         fails_in  = 8'd0;
         good_in   = dist_cm16;
         caller_in = dist_cm16;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         cnt_ff    <= 16'd0;
         fails_ff  <= 8'd0;
         good_ff   <= 13'd0;
         caller_ff <= 13'd0;
      end else if (step) begin
         phase_ff  <= phase_in;
         cnt_ff    <= cnt_in;
         fails_ff  <= fails_in;
         good_ff   <= good_in;
         caller_ff <= caller_in;
      end
   end

   always_comb begin
      rsp.trigger            = trig;
      rsp.busy_res           = (phase_in != PH_IDLE);
      rsp.done_res           = done;
      rsp.status             = status;
      rsp.reported_distance  = caller_in;
      rsp.last_good_distance = good_in;
      rsp.failures           = fails_in;
   end

endmodule

>>> rtl/core/uer_checker.sv
// ----------------------------------------------------------------------------
// Echo ranger port checker
// Result-channel consistency checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "ultrasonic_echo_ranger_top_defines.svh"

module uer_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata
);
   import uer_pkg::*;

   `UER_ASSERT_NOW(a_done_not_busy, clock, reset, rsp_tvalid && rsp_tdata[2], !rsp_tdata[1], "done result still busy")
   `UER_ASSERT_NOW(a_status_only_on_done, clock, reset, rsp_tvalid && !rsp_tdata[2], rsp_tdata[5:3] == ST_OK, "status set without done")
   `UER_ASSERT_NOW(a_trigger_in_busy, clock, reset, rsp_tvalid && rsp_tdata[0], rsp_tdata[1] && !rsp_tdata[2], "trigger outside measurement")
   `UER_ASSERT_NOW(a_ok_clears_fails, clock, reset, rsp_tvalid && rsp_tdata[2] && rsp_tdata[5:3] == ST_OK, rsp_tdata[39:32] == 8'd0 && rsp_tdata[18:6] == rsp_tdata[31:19], "good result without cleared count")
   `UER_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled result changed")

endmodule

bind ultrasonic_echo_ranger_top uer_checker u_uer_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
